// File: rtl/tdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdm_pkg
// Shared widths, result kind codes and sequencer state type for the task
// dependency matrix.
// ----------------------------------------------------------------------------
package tdm_pkg;

    localparam int DEP_W  = 32;
    localparam int SLOT_W = 5;
    localparam int KIND_W = 3;

    localparam logic [KIND_W-1:0] KIND_ADDED_WAIT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_ADDED_RDY  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASED   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FIN_DONE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FULL       = 3'd4;
    localparam logic [KIND_W-1:0] KIND_EMPTY_SLOT = 3'd5;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_FINISH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic pop;
        logic push;
    } t_stack_ctrl;

endpackage

// File: rtl/tdm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdm_if
// Valid/ready channels for task requests and scheduler results.
// ----------------------------------------------------------------------------
interface tdm_in_if;
    logic                       valid;
    logic                       ready;
    logic                       action;
    logic [tdm_pkg::DEP_W-1:0]  dep_mask;
    logic [tdm_pkg::SLOT_W-1:0] slot;

    modport source (output valid, action, dep_mask, slot, input ready);
    modport sink   (input valid, action, dep_mask, slot, output ready);
endinterface

interface tdm_out_if;
    logic                       valid;
    logic                       ready;
    logic [tdm_pkg::KIND_W-1:0] kind;
    logic [tdm_pkg::SLOT_W-1:0] slot_id;
    logic                       last;

    modport source (output valid, kind, slot_id, last, input ready);
    modport sink   (input valid, kind, slot_id, last, output ready);
endinterface

// File: rtl/tdm_row_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdm_row_unit
// Shared row update: clears one dependence bit in a row and flags a row that
// just became empty.
// ----------------------------------------------------------------------------
module tdm_row_unit #(
    parameter int NSLOT = 32,
    parameter int IDX_W = 5
) (
    input  logic [NSLOT-1:0] i_row,
    input  logic [IDX_W-1:0] i_idx,
    output logic [NSLOT-1:0] o_row,
    output logic             o_release
);

    always_comb begin
        o_row        = i_row;
        o_row[i_idx] = 1'b0;
        o_release    = (|i_row) && !(|o_row);
    end

endmodule

// File: rtl/tdm_free_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdm_free_stack
// LIFO of free slot numbers with fill count; entry k holds k after reset.
// ----------------------------------------------------------------------------
module tdm_free_stack #(
    parameter int NSLOT = 32,
    parameter int IDX_W = 5,
    parameter int CNT_W = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tdm_pkg::t_stack_ctrl i_ctrl,
    input  logic [IDX_W-1:0]     i_push_id,
    output logic [IDX_W-1:0]     o_top_id,
    output logic                 o_empty,
    output logic [CNT_W-1:0]     o_count
);

    logic [IDX_W-1:0] r_stack [NSLOT];
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] w_top_idx;
    logic [IDX_W-1:0] w_push_idx;
    logic             w_can_push;

    assign w_top_idx  = IDX_W'(r_count - 1'b1);
    assign w_push_idx = IDX_W'(r_count);
    assign w_can_push = (r_count < CNT_W'(NSLOT));
    assign o_top_id   = r_stack[w_top_idx];
    assign o_empty    = (r_count == '0);
    assign o_count    = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CNT_W'(NSLOT);
            for (int k = 0; k < NSLOT; k++) begin
                r_stack[k] <= IDX_W'(k);
            end
        end else begin
            if (i_ctrl.pop && !o_empty) begin
                r_count <= r_count - 1'b1;
            end else if (i_ctrl.push && w_can_push) begin
                r_stack[w_push_idx] <= i_push_id;
                r_count             <= r_count + 1'b1;
            end
        end
    end

endmodule

// File: rtl/task_dependency_matrix.sv
`timescale 1ns / 1ps
// an add or a rejected item gives its single beat through the decode state and the output register
// a new request is accepted only in the idle state, once the previous one has finished
// a finish scans one dependence row per cycle through the row unit while the output is free
// reset: all rows clear, no slot occupied, free stack full with slot NSLOT-1 on top
// ----------------------------------------------------------------------------
// task_dependency_matrix
// Task slot table with a dependence bit matrix, a LIFO free slot stack and a
// sequencer that scans the rows on every finish of an occupied slot to release ready tasks.
// ----------------------------------------------------------------------------
module task_dependency_matrix #(
    parameter int SLOTS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tdm_in_if.sink           i_in,
    tdm_out_if.source        o_out
);

    localparam int NSLOT = (SLOTS < 32) ? SLOTS : 32;
    localparam int IDX_W = $clog2(NSLOT);
    localparam int CNT_W = $clog2(NSLOT + 1);

    tdm_pkg::t_state r_state;
    tdm_pkg::t_state n_state;

    logic                       r_action;
    logic [tdm_pkg::DEP_W-1:0]  r_mask;
    logic [tdm_pkg::SLOT_W-1:0] r_slot;
    logic [NSLOT-1:0]           r_occ;
    logic [NSLOT-1:0]           r_rows [NSLOT];
    logic [IDX_W-1:0]           r_scan;

    logic                       r_out_valid;
    logic [tdm_pkg::KIND_W-1:0] r_out_kind;
    logic [tdm_pkg::SLOT_W-1:0] r_out_id;
    logic                       r_out_last;

    logic                       w_out_free;
    logic                       w_slot_ok;
    logic [IDX_W-1:0]           w_slot_idx;
    logic [NSLOT-1:0]           w_add_row;
    logic [NSLOT-1:0]           w_row_next;
    logic                       w_release;
    logic [IDX_W-1:0]           w_top_id;
    logic                       w_empty;
    logic [CNT_W-1:0]           w_count;
    tdm_pkg::t_stack_ctrl       w_stack;

    logic                       w_out_load;
    logic [tdm_pkg::KIND_W-1:0] w_out_kind;
    logic [tdm_pkg::SLOT_W-1:0] w_out_id;
    logic                       w_out_last;
    logic                       w_add_commit;
    logic                       w_fin_commit;
    logic                       w_scan_step;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_slot_idx = r_slot[IDX_W-1:0];
    assign w_slot_ok  = (6'(r_slot) < 6'(NSLOT)) && r_occ[w_slot_idx];
    assign w_add_row  = r_mask[NSLOT-1:0] & r_occ;

    assign i_in.ready    = (r_state == tdm_pkg::ST_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.kind    = r_out_kind;
    assign o_out.slot_id = r_out_id;
    assign o_out.last    = r_out_last;

    tdm_row_unit #(
        .NSLOT (NSLOT),
        .IDX_W (IDX_W)
    ) u_row_unit (
        .i_row     (r_rows[r_scan]),
        .i_idx     (w_slot_idx),
        .o_row     (w_row_next),
        .o_release (w_release)
    );

    tdm_free_stack #(
        .NSLOT (NSLOT),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_free_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_stack),
        .i_push_id (w_slot_idx),
        .o_top_id  (w_top_id),
        .o_empty   (w_empty),
        .o_count   (w_count)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tdm_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = tdm_pkg::ST_DECODE;
                end
            end
            tdm_pkg::ST_DECODE: begin
                if (w_out_free) begin
                    if (r_action == tdm_pkg::ACT_ADD || !w_slot_ok) begin
                        n_state = tdm_pkg::ST_IDLE;
                    end else begin
                        n_state = tdm_pkg::ST_SCAN;
                    end
                end
            end
            tdm_pkg::ST_SCAN: begin
                if (w_out_free && r_scan == IDX_W'(NSLOT - 1)) begin
                    n_state = tdm_pkg::ST_DONE;
                end
            end
            tdm_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = tdm_pkg::ST_IDLE;
                end
            end
            default: n_state = tdm_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_out_load   = 1'b0;
        w_out_kind   = tdm_pkg::KIND_FIN_DONE;
        w_out_id     = r_slot;
        w_out_last   = 1'b1;
        w_stack      = '0;
        w_add_commit = 1'b0;
        w_fin_commit = 1'b0;
        w_scan_step  = 1'b0;
        unique case (r_state)
            tdm_pkg::ST_IDLE: begin
            end
            tdm_pkg::ST_DECODE: begin
                if (w_out_free) begin
                    if (r_action == tdm_pkg::ACT_ADD) begin
                        w_out_load = 1'b1;
                        if (w_empty) begin
                            w_out_kind = tdm_pkg::KIND_FULL;
                            w_out_id   = '0;
                        end else begin
                            w_out_kind   = (w_add_row == '0) ? tdm_pkg::KIND_ADDED_RDY
                                                             : tdm_pkg::KIND_ADDED_WAIT;
                            w_out_id     = tdm_pkg::SLOT_W'(w_top_id);
                            w_stack.pop  = 1'b1;
                            w_add_commit = 1'b1;
                        end
                    end else if (!w_slot_ok) begin
                        w_out_load = 1'b1;
                        w_out_kind = tdm_pkg::KIND_EMPTY_SLOT;
                    end else begin
                        w_stack.push = 1'b1;
                        w_fin_commit = 1'b1;
                    end
                end
            end
            tdm_pkg::ST_SCAN: begin
                if (w_out_free) begin
                    w_scan_step = 1'b1;
                    if (w_release) begin
                        w_out_load = 1'b1;
                        w_out_kind = tdm_pkg::KIND_RELEASED;
                        w_out_id   = tdm_pkg::SLOT_W'(r_scan);
                        w_out_last = 1'b0;
                    end
                end
            end
            tdm_pkg::ST_DONE: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_action <= i_in.action;
            r_mask   <= i_in.dep_mask;
            r_slot   <= i_in.slot;
        end
    end

    // occupancy and row scan pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ  <= '0;
            r_scan <= '0;
        end else begin
            if (w_add_commit) begin
                r_occ[w_top_id] <= 1'b1;
            end else if (w_fin_commit) begin
                r_occ[w_slot_idx] <= 1'b0;
            end
            if (w_fin_commit) begin
                r_scan <= '0;
            end else if (w_scan_step) begin
                r_scan <= r_scan + 1'b1;
            end
        end
    end

    // dependence rows
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSLOT; i++) begin
                r_rows[i] <= '0;
            end
        end else begin
            for (int i = 0; i < NSLOT; i++) begin
                if (w_add_commit && w_top_id == IDX_W'(i)) begin
                    r_rows[i] <= w_add_row;
                end else if (w_fin_commit && w_slot_idx == IDX_W'(i)) begin
                    r_rows[i] <= '0;
                end else if (w_scan_step && r_scan == IDX_W'(i)) begin
                    r_rows[i] <= w_row_next;
                end
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_kind <= w_out_kind;
            r_out_id   <= w_out_id;
            r_out_last <= w_out_last;
        end
    end

    a_slot_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W + 1)'($countones(r_occ)) + (CNT_W + 1)'(w_count) == (CNT_W + 1)'(NSLOT))
        else $error("occupied and free slot counts disagree");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> w_out_free)
        else $error("result beat overwritten before it was taken");

    a_pop_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_add_commit |-> !r_occ[w_top_id])
        else $error("allocated slot already occupied");

    a_fin_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin_commit |=> !r_occ[$past(w_slot_idx)] && r_rows[$past(w_slot_idx)] == '0)
        else $error("finished slot not cleared");

    a_release_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && w_scan_step) |-> !w_out_last)
        else $error("release beat marked as final");

endmodule
